@@ src/gcdc_pkg.sv @@
// Shared types, codes and the microcode table of the gcd and coprime check block.
package gcdc_pkg;

  localparam int DataWidth = 32;
  localparam int PcWidth   = 3;
  localparam int ShWidth   = $clog2(DataWidth);

  typedef enum logic [1:0] {
    StNotCoprime = 2'd0,
    StCoprime    = 2'd1,
    StInvalid    = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [DataWidth-1:0] operand_a;
    logic signed [DataWidth-1:0] operand_b;
  } in_data_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] gcd_value;
    logic [1:0]                  relation_status;
  } out_data_t;

  // Handshake from the top level into the gcd engine.
  typedef struct packed {
    logic start;
    logic ack;
  } eng_ctrl_t;

  typedef enum logic [2:0] {
    CondAlways,
    CondStart,
    CondBothEven,
    CondXEven,
    CondYZero,
    CondYEven,
    CondShNonzero,
    CondAck
  } cond_e;

  typedef enum logic [2:0] {
    ActNop,
    ActLoad,
    ActShrBoth,
    ActShrX,
    ActShrY,
    ActSub,
    ActShlX
  } act_e;

  typedef struct packed {
    cond_e              cond;
    act_e               act_t;
    logic [PcWidth-1:0] next_t;
    act_e               act_f;
    logic [PcWidth-1:0] next_f;
  } uword_t;

  localparam logic [PcWidth-1:0] PcCommon = 3'd0;
  localparam logic [PcWidth-1:0] PcOddX   = 3'd1;
  localparam logic [PcWidth-1:0] PcTest   = 3'd2;
  localparam logic [PcWidth-1:0] PcReduce = 3'd3;
  localparam logic [PcWidth-1:0] PcScale  = 3'd4;
  localparam logic [PcWidth-1:0] PcDone   = 3'd5;
  localparam logic [PcWidth-1:0] PcIdle   = 3'd6;
  localparam logic [PcWidth-1:0] PcSpare  = 3'd7;

  // Binary Euclid as a microprogram: strip common twos, make x odd,
  // reduce y by shift and subtract until zero, then restore the twos.
  function automatic uword_t ucode_rom(logic [PcWidth-1:0] pc);
    uword_t w;
    unique case (pc)
      PcIdle:   w = '{CondStart,     ActLoad,    PcCommon, ActNop, PcIdle};
      PcCommon: w = '{CondBothEven,  ActShrBoth, PcCommon, ActNop, PcOddX};
      PcOddX:   w = '{CondXEven,     ActShrX,    PcOddX,   ActNop, PcTest};
      PcTest:   w = '{CondYZero,     ActNop,     PcScale,  ActNop, PcReduce};
      PcReduce: w = '{CondYEven,     ActShrY,    PcReduce, ActSub, PcTest};
      PcScale:  w = '{CondShNonzero, ActShlX,    PcScale,  ActNop, PcDone};
      PcDone:   w = '{CondAck,       ActNop,     PcIdle,   ActNop, PcDone};
      default:  w = '{CondAlways,    ActNop,     PcIdle,   ActNop, PcIdle};
    endcase
    return w;
  endfunction

endpackage

@@ src/gcdc_engine.sv @@
// Microcoded binary Euclid engine: step counter, control store and shift-subtract datapath.
module gcdc_engine (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  gcdc_pkg::eng_ctrl_t                 ctrl_i,
  input  logic [gcdc_pkg::DataWidth-1:0]      a_i,
  input  logic [gcdc_pkg::DataWidth-1:0]      b_i,
  output logic                                done_o,
  output logic [gcdc_pkg::DataWidth-1:0]      gcd_o
);

  logic [gcdc_pkg::PcWidth-1:0]   pc_q, pc_d;
  logic [gcdc_pkg::DataWidth-1:0] x_q, x_d, y_q, y_d;
  logic [gcdc_pkg::ShWidth-1:0]   sh_q, sh_d;
  gcdc_pkg::uword_t               uw;
  gcdc_pkg::act_e                 act;
  logic                           cond;
  logic                           x_gt_y;
  logic [gcdc_pkg::DataWidth-1:0] diff_xy, diff_yx;

  assign uw = gcdc_pkg::ucode_rom(pc_q);

  always_comb begin
    unique case (uw.cond)
      gcdc_pkg::CondAlways:    cond = 1'b1;
      gcdc_pkg::CondStart:     cond = ctrl_i.start;
      gcdc_pkg::CondBothEven:  cond = ~(x_q[0] | y_q[0]);
      gcdc_pkg::CondXEven:     cond = ~x_q[0];
      gcdc_pkg::CondYZero:     cond = (y_q == '0);
      gcdc_pkg::CondYEven:     cond = ~y_q[0];
      gcdc_pkg::CondShNonzero: cond = (sh_q != '0);
      gcdc_pkg::CondAck:       cond = ctrl_i.ack;
      default:                 cond = 1'b0;
    endcase
  end

  assign act     = cond ? uw.act_t : uw.act_f;
  assign pc_d    = cond ? uw.next_t : uw.next_f;
  assign x_gt_y  = (x_q > y_q);
  assign diff_xy = x_q - y_q;
  assign diff_yx = y_q - x_q;

  always_comb begin
    x_d  = x_q;
    y_d  = y_q;
    sh_d = sh_q;
    unique case (act)
      gcdc_pkg::ActNop: begin
      end
      gcdc_pkg::ActLoad: begin
        x_d  = a_i;
        y_d  = b_i;
        sh_d = '0;
      end
      gcdc_pkg::ActShrBoth: begin
        x_d  = x_q >> 1;
        y_d  = y_q >> 1;
        sh_d = sh_q + 1'b1;
      end
      gcdc_pkg::ActShrX: x_d = x_q >> 1;
      gcdc_pkg::ActShrY: y_d = y_q >> 1;
      gcdc_pkg::ActSub: begin
        // keep the smaller value in x, the difference in y
        if (x_gt_y) begin
          x_d = y_q;
          y_d = diff_xy;
        end else begin
          y_d = diff_yx;
        end
      end
      gcdc_pkg::ActShlX: begin
        x_d  = x_q << 1;
        sh_d = sh_q - 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= gcdc_pkg::PcIdle;
    end else begin
      pc_q <= pc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q  <= x_d;
    y_q  <= y_d;
    sh_q <= sh_d;
  end

  assign done_o = (pc_q == gcdc_pkg::PcDone);
  assign gcd_o  = x_q;

endmodule

@@ src/gcd_and_coprime_check_top.sv @@
// Top level of the gcd and coprime check block: handshakes, special cases, result register.
// Equal, zero or negative operands bypass the engine; the result is stored at acceptance.
// Two unequal positive operands: data dependent, set by the microcode loop of the engine
//   (at most one shift or subtract per cycle).
// One item is in work at a time; the next transaction is accepted the cycle after the
//   result enters the output register, where it waits. Reset returns the control to idle.
module gcd_and_coprime_check_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  gcdc_pkg::in_data_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output gcdc_pkg::out_data_t  out_data_o
);

  localparam int W = gcdc_pkg::DataWidth;

  logic                 busy_q, busy_d;
  logic                 special_q;
  gcdc_pkg::out_data_t  spec_q, spec_d;
  logic                 out_valid_q, out_valid_d;
  gcdc_pkg::out_data_t  out_q, res;
  logic                 in_fire, a_pos, b_pos, equal, special;
  logic                 result_rdy, load_out;
  gcdc_pkg::eng_ctrl_t  eng_ctrl;
  logic                 eng_done;
  logic [W-1:0]         eng_gcd;

  assign in_ready_o = ~busy_q;
  assign in_fire    = in_valid_i & in_ready_o;

  assign equal   = (in_data_i.operand_a == in_data_i.operand_b);
  assign a_pos   = ~in_data_i.operand_a[W-1] & (in_data_i.operand_a != '0);
  assign b_pos   = ~in_data_i.operand_b[W-1] & (in_data_i.operand_b != '0);
  assign special = equal | ~a_pos | ~b_pos;

  always_comb begin
    if (equal) begin
      spec_d.gcd_value       = in_data_i.operand_a;
      spec_d.relation_status = gcdc_pkg::StNotCoprime;
    end else begin
      spec_d.gcd_value       = '1;
      spec_d.relation_status = gcdc_pkg::StInvalid;
    end
  end

  assign result_rdy = busy_q & (special_q | eng_done);
  assign load_out   = result_rdy & (~out_valid_q | out_ready_i);

  assign eng_ctrl.start = in_fire & ~special;
  assign eng_ctrl.ack   = load_out & ~special_q;

  gcdc_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (eng_ctrl),
    .a_i    (in_data_i.operand_a),
    .b_i    (in_data_i.operand_b),
    .done_o (eng_done),
    .gcd_o  (eng_gcd)
  );

  always_comb begin
    if (special_q) begin
      res = spec_q;
    end else begin
      res.gcd_value       = eng_gcd;
      res.relation_status = (eng_gcd == W'(1)) ? gcdc_pkg::StCoprime
                                               : gcdc_pkg::StNotCoprime;
    end
  end

  always_comb begin
    busy_d = busy_q;
    if (load_out) busy_d = 1'b0;
    if (in_fire)  busy_d = 1'b1;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (load_out)                   out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      special_q <= special;
      spec_q    <= spec_d;
    end
    if (load_out) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // the engine only finishes for an item that is still held
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eng_done |-> busy_q)
    else $error("engine done without an item in work");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> busy_q && !in_ready_o)
    else $error("accepted transaction not held");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> out_valid_o)
    else $error("loaded result not presented");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.relation_status == gcdc_pkg::StNotCoprime ||
                     out_data_o.relation_status == gcdc_pkg::StCoprime ||
                     out_data_o.relation_status == gcdc_pkg::StInvalid))
    else $error("unused status code on output");
`endif

endmodule

@@ sim/gcd_and_coprime_check_top_tb.sv @@
// Testbench for the gcd and coprime check block: directed table, random operands, scoreboard.
module gcd_and_coprime_check_top_tb;

  localparam int DataWidth   = gcdc_pkg::DataWidth;
  localparam int CycleLimit  = 1000000;
  localparam int RandomItems = 1400;
  localparam int DrainCycles = 200;

  localparam logic signed [DataWidth-1:0] OpMax = {1'b0, {(DataWidth-1){1'b1}}};
  localparam logic signed [DataWidth-1:0] OpMin = {1'b1, {(DataWidth-1){1'b0}}};
  localparam longint unsigned OpMaxU = (64'd1 << (DataWidth - 1)) - 1;

  typedef struct {
    gcdc_pkg::in_data_t  op;
    bit                  typed;
    gcdc_pkg::out_data_t want;
  } stim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid;
  logic                in_ready;
  gcdc_pkg::in_data_t  in_data;
  logic                out_valid;
  logic                out_ready;
  gcdc_pkg::out_data_t out_data;

  gcdc_pkg::out_data_t gcd_expect_q[$];
  stim_row_t           stim_rows[$];
  gcdc_pkg::out_data_t want_res;
  bit                  steady;
  int                  mismatch_count;
  int                  cycle_count;
  int                  n_checked, n_coprime, n_not_coprime, n_invalid, n_equal;

  gcd_and_coprime_check_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always #1 clk_i = ~clk_i;

  // Binary Euclid with the block's handling of equal and nonpositive operands.
  function automatic gcdc_pkg::out_data_t predict_gcd(gcdc_pkg::in_data_t op);
    logic [DataWidth-1:0] x, y, t;
    int unsigned          twos;
    gcdc_pkg::out_data_t  res;
    x    = op.operand_a;
    y    = op.operand_b;
    twos = 0;
    if (x == y) begin
      res.gcd_value       = op.operand_a;
      res.relation_status = gcdc_pkg::StNotCoprime;
    end else if ($signed(op.operand_a) <= 0 || $signed(op.operand_b) <= 0) begin
      res.gcd_value       = '1;
      res.relation_status = gcdc_pkg::StInvalid;
    end else begin
      while (!x[0] && !y[0]) begin
        x = x >> 1;
        y = y >> 1;
        twos++;
      end
      while (!x[0]) x = x >> 1;
      while (y != 0) begin
        while (!y[0]) y = y >> 1;
        if (x > y) begin
          t = x;
          x = y;
          y = t;
        end
        y = y - x;
      end
      x = x << twos;
      res.gcd_value       = x;
      res.relation_status = (x == 1) ? gcdc_pkg::StCoprime : gcdc_pkg::StNotCoprime;
    end
    return res;
  endfunction

  task automatic add_row(input logic signed [DataWidth-1:0] a, input logic signed [DataWidth-1:0] b,
                         input bit typed = 1'b0, input logic signed [DataWidth-1:0] g = '0,
                         input gcdc_pkg::status_e st = gcdc_pkg::StNotCoprime);
    stim_row_t row;
    row.op.operand_a          = a;
    row.op.operand_b          = b;
    row.typed                 = typed;
    row.want.gcd_value        = g;
    row.want.relation_status  = st;
    stim_rows.push_back(row);
  endtask

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_operands(input gcdc_pkg::in_data_t op, input gcdc_pkg::out_data_t want);
    while (!steady && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    do @(posedge clk_i); while (!in_ready);
    gcd_expect_q.push_back(want);
    if (op.operand_a == op.operand_b) n_equal++;
    case (want.relation_status)
      gcdc_pkg::StCoprime:    n_coprime++;
      gcdc_pkg::StNotCoprime: n_not_coprime++;
      default:                n_invalid++;
    endcase
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 12);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (gcd_expect_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result gcd_value %0d status %0d", $time,
                 $signed(out_data.gcd_value), out_data.relation_status);
      end else begin
        want_res = gcd_expect_q.pop_front();
        n_checked++;
        if (out_data.gcd_value !== want_res.gcd_value) begin
          mismatch_count++;
          $display("%0t: gcd_value expected %0d got %0d", $time,
                   $signed(want_res.gcd_value), $signed(out_data.gcd_value));
        end
        if (out_data.relation_status !== want_res.relation_status) begin
          mismatch_count++;
          $display("%0t: relation_status expected %0d got %0d", $time,
                   want_res.relation_status, out_data.relation_status);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, gcd_expect_q.size());
      $display("[gcd_and_coprime_check_top] ERROR");
      $finish;
    end
  end

  initial begin
    gcdc_pkg::in_data_t op;
    int                 pick;
    longint unsigned    scale, span;
    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    steady    = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // equal operands pass straight through
    add_row(0, 0, 1'b1, 0, gcdc_pkg::StNotCoprime);
    add_row(1, 1, 1'b1, 1, gcdc_pkg::StNotCoprime);
    add_row(-1, -1, 1'b1, -1, gcdc_pkg::StNotCoprime);
    add_row(OpMin, OpMin, 1'b1, OpMin, gcdc_pkg::StNotCoprime);
    add_row(OpMax, OpMax, 1'b1, OpMax, gcdc_pkg::StNotCoprime);
    // unequal with a zero or negative side, then unequal positive pairs
    add_row(0, 5, 1'b1, -1, gcdc_pkg::StInvalid);
    add_row(5, 0, 1'b1, -1, gcdc_pkg::StInvalid);
    add_row(-3, 7, 1'b1, -1, gcdc_pkg::StInvalid);
    add_row(7, -3, 1'b1, -1, gcdc_pkg::StInvalid);
    add_row(OpMin, OpMax, 1'b1, -1, gcdc_pkg::StInvalid);
    add_row(OpMax, OpMin, 1'b1, -1, gcdc_pkg::StInvalid);
    add_row(-1, OpMin, 1'b1, -1, gcdc_pkg::StInvalid);
    add_row(0, -1, 1'b1, -1, gcdc_pkg::StInvalid);
    add_row(1, OpMax, 1'b1, 1, gcdc_pkg::StCoprime);
    add_row(OpMax, 1, 1'b1, 1, gcdc_pkg::StCoprime);
    add_row(OpMax, OpMax - 1, 1'b1, 1, gcdc_pkg::StCoprime);
    add_row(12, 18);
    add_row(2, 4);
    add_row(1, 2);
    add_row(32'sh4000_0000, 32'sh2000_0000);
    add_row(32'sh4000_0000, 32'sh7fff_fffe);
    add_row(32'sh5555_5555, 32'sh2aaa_aaaa);
    add_row(15015, 17017);
    add_row(65536, 3);
    foreach (stim_rows[i]) begin
      send_operands(stim_rows[i].op,
                    stim_rows[i].typed ? stim_rows[i].want : predict_gcd(stim_rows[i].op));
    end

    for (int n = 0; n < RandomItems; n++) begin
      steady = (n >= 500 && n < 800);
      pick   = $urandom_range(0, 99);
      if (pick < 55) begin
        // shared factor with a random power of two on top
        scale        = longint'($urandom_range(1, 1000)) << $urandom_range(0, 12);
        span         = OpMaxU / scale;
        op.operand_a = DataWidth'(scale * $urandom_range(1, 32'(span)));
        op.operand_b = DataWidth'(scale * $urandom_range(1, 32'(span)));
      end else if (pick < 70) begin
        op.operand_a = $urandom & OpMax;
        op.operand_b = $urandom & OpMax;
      end else if (pick < 80) begin
        op.operand_a = $urandom;
        op.operand_b = op.operand_a;
      end else if (pick < 93) begin
        op.operand_a = $urandom;
        op.operand_b = $urandom;
      end else begin
        op.operand_a = int'($urandom_range(0, 12)) - 4;
        op.operand_b = int'($urandom_range(0, 12)) - 4;
      end
      send_operands(op, predict_gcd(op));
    end
    steady   = 1'b0;
    in_valid <= 1'b0;

    while (gcd_expect_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d transactions (%0d equal pairs), checked %0d results;",
             n_coprime + n_not_coprime + n_invalid, n_equal, n_checked);
    $display("  %0d coprime, %0d not coprime, %0d invalid, %0d mismatches.",
             n_coprime, n_not_coprime, n_invalid, mismatch_count);
    if (mismatch_count == 0) begin
      $display("[gcd_and_coprime_check_top] OK");
    end else begin
      $display("[gcd_and_coprime_check_top] ERROR");
    end
    $finish;
  end

endmodule
